// ===== design/dxtdec_pkg.sv =====
// Shared types and constants of the DXT1/DXT5 block decoder.
`timescale 1ns / 1ps

package dxtdec_pkg;

    localparam int PIX_IDX_W = 24;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IDX_FORMAT = 2'd0;
    localparam logic [1:0] CFG_IDX_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IDX_HEIGHT = 2'd2;

    typedef struct packed {
        logic        fmt_dxt5;
        logic [12:0] width;
        logic [12:0] height;
    } t_cfg;

    // One decoded block header as it travels from the front end to the pixel engine.
    // Colour entries are packed {alpha, blue, green, red}, red in the lowest byte.
    typedef struct packed {
        logic [3:0][31:0]          pal;
        logic [7:0][7:0]           apal;
        logic [31:0]               cidx;
        logic [47:0]               aidx;
        logic                      dxt5;
        logic [PIX_IDX_W-1:0]      base;
        logic [PIX_IDX_W-1:0]      step;
        logic                      last_img;
    } t_blk;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== design/dxtdec_front.sv =====
// Front end: accepts compressed blocks, tracks block position and builds the palettes.
`timescale 1ns / 1ps

module dxtdec_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dxtdec_pkg::t_cfg  i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [127:0]      i_data,
    output logic              o_push,
    output dxtdec_pkg::t_blk  o_blk,
    input  logic              i_full
);
    import dxtdec_pkg::*;

    localparam int MaxDimRaw = MAX_DIMENSION - (MAX_DIMENSION % 4);
    localparam int MaxDim    = (MaxDimRaw < 4) ? 4 : MaxDimRaw;
    localparam int DimW      = $clog2(MaxDim + 1);
    localparam int BlkW      = ($clog2(MaxDim / 4) < 1) ? 1 : $clog2(MaxDim / 4);
    localparam int ProdW     = BlkW + 2 + DimW;

    function automatic logic [DimW-1:0] eff_dim(input logic [12:0] v);
        logic [12:0] r;
        r = {v[12:2], 2'b00};
        if (r < 13'd4) begin
            r = 13'd4;
        end
        if (int'(r) > MaxDim) begin
            return DimW'(MaxDim);
        end
        return DimW'(r);
    endfunction

    // RGB565 to 8-bit channels by bit replication, packed {blue, green, red}.
    function automatic logic [23:0] expand565(input logic [15:0] v);
        return {v[4:0], v[4:2], v[10:5], v[10:9], v[15:11], v[15:13]};
    endfunction

    // Division by small constants through a scaled reciprocal; exact over the ranges used.
    function automatic logic [7:0] div3(input logic [9:0] n);
        logic [20:0] p;
        p = 21'(n) * 21'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] n);
        logic [22:0] p;
        p = 23'(n) * 23'd3277;
        return p[21:14];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] n);
        logic [22:0] p;
        p = 23'(n) * 23'd2341;
        return p[21:14];
    endfunction

    logic [BlkW-1:0]      r_col, r_row;
    logic [BlkW-1:0]      n_col, n_row;
    logic                 r1_v, n1_v;
    logic [63:0]          r1_cword, r1_aword;
    logic                 r1_dxt5;
    logic [PIX_IDX_W-1:0] r1_rowpix, r1_col4, r1_step;
    logic                 r1_last;

    logic [DimW-1:0]      w_w, w_h, w_bw, w_bh;
    logic                 w_last_col, w_last_row, w_accept;
    logic [ProdW-1:0]     w_prod;

    assign w_w  = eff_dim(i_cfg.width);
    assign w_h  = eff_dim(i_cfg.height);
    assign w_bw = w_w >> 2;
    assign w_bh = w_h >> 2;
    // A position at or beyond the limit counts as the last one, so a shrunk image wraps.
    assign w_last_col = (int'(r_col) + 1) >= int'(w_bw);
    assign w_last_row = (int'(r_row) + 1) >= int'(w_bh);
    assign w_prod     = ProdW'({r_row, 2'b00}) * ProdW'(w_w);

    assign o_ready  = !r1_v || !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = r1_v && !i_full;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        n1_v = r1_v;
        if (w_accept) begin
            n1_v = 1'b1;
        end else if (o_push) begin
            n1_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r1_v  <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r1_v  <= n1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r1_dxt5   <= i_cfg.fmt_dxt5;
            r1_cword  <= i_cfg.fmt_dxt5 ? i_data[127:64] : i_data[63:0];
            r1_aword  <= i_data[63:0];
            r1_rowpix <= PIX_IDX_W'(w_prod);
            r1_col4   <= PIX_IDX_W'({r_col, 2'b00});
            r1_step   <= PIX_IDX_W'(w_w);
            r1_last   <= w_last_col && w_last_row;
        end
    end

    // Palette construction for the block held in the staging register.
    logic [15:0] w_c0raw, w_c1raw;
    logic [23:0] w_e0, w_e1;
    logic        w_four, w_seven;
    logic [7:0]  w_a0, w_a1, w_ca, w_cb;
    logic [9:0]  w_n2, w_n3, w_nm;
    logic [10:0] w_n7, w_n5;
    logic [7:0]  w_q7, w_q5;

    always_comb begin
        w_c0raw = r1_cword[15:0];
        w_c1raw = r1_cword[31:16];
        w_e0    = expand565(w_c0raw);
        w_e1    = expand565(w_c1raw);
        w_four  = r1_dxt5 || (w_c0raw > w_c1raw);
        w_a0    = r1_aword[7:0];
        w_a1    = r1_aword[15:8];
        w_seven = w_a0 > w_a1;

        o_blk          = '0;
        o_blk.pal[0]   = {8'd255, w_e0};
        o_blk.pal[1]   = {8'd255, w_e1};
        o_blk.pal[2][31:24] = 8'd255;
        o_blk.pal[3][31:24] = w_four ? 8'd255 : 8'd0;
        for (int ch = 0; ch < 3; ch++) begin
            w_ca = w_e0[ch*8 +: 8];
            w_cb = w_e1[ch*8 +: 8];
            w_n2 = {1'b0, w_ca, 1'b0} + 10'(w_cb);
            w_n3 = 10'(w_ca) + {1'b0, w_cb, 1'b0};
            w_nm = 10'(w_ca) + 10'(w_cb);
            o_blk.pal[2][ch*8 +: 8] = w_four ? div3(w_n2) : w_nm[8:1];
            o_blk.pal[3][ch*8 +: 8] = w_four ? div3(w_n3) : 8'd0;
        end

        o_blk.apal[0] = w_a0;
        o_blk.apal[1] = w_a1;
        for (int i = 1; i < 7; i++) begin
            w_n7 = 11'(w_a0) * 11'(7 - i) + 11'(w_a1) * 11'(i);
            w_q7 = div7(w_n7);
            if (i < 5) begin
                w_n5 = 11'(w_a0) * 11'(5 - i) + 11'(w_a1) * 11'(i);
                w_q5 = div5(w_n5);
            end else begin
                w_n5 = '0;
                w_q5 = (i == 5) ? 8'd0 : 8'd255;
            end
            o_blk.apal[i+1] = w_seven ? w_q7 : w_q5;
        end

        o_blk.cidx     = r1_cword[63:32];
        o_blk.aidx     = r1_aword[63:16];
        o_blk.dxt5     = r1_dxt5;
        o_blk.base     = r1_rowpix + r1_col4;
        o_blk.step     = r1_step;
        o_blk.last_img = r1_last;
    end

endmodule

// ===== design/dxtdec_fifo.sv =====
// Two-entry queue of decoded block headers between the front end and the pixel engine.
`timescale 1ns / 1ps

module dxtdec_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dxtdec_pkg::t_blk    i_blk,
    input  logic                i_pop,
    output dxtdec_pkg::t_blk    o_blk,
    output dxtdec_pkg::t_q_stat o_stat
);
    import dxtdec_pkg::*;

    t_blk       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       n_wr, n_rd;
    logic [1:0] n_cnt;

    assign o_blk        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_comb begin
        n_wr  = i_push ? !r_wr : r_wr;
        n_rd  = i_pop ? !r_rd : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_blk;
        end
    end

endmodule

// ===== design/dxtdec_back.sv =====
// Pixel engine: walks the head block's 16 texels, one pixel per cycle unless stalled.
`timescale 1ns / 1ps

module dxtdec_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dxtdec_pkg::t_blk    i_blk,
    input  dxtdec_pkg::t_q_stat i_stat,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [55:0]         o_data,
    output logic                o_last,
    output logic                o_user
);
    import dxtdec_pkg::*;

    logic [3:0]           r_k, n_k;
    logic                 r_out_v, n_out_v;
    logic [PIX_IDX_W-1:0] r_row_base, n_row_base;
    logic [55:0]          r_data;
    logic                 r_last, r_user;

    logic                 w_load;
    logic [PIX_IDX_W-1:0] w_cur_base;
    logic [1:0]           w_ci;
    logic [5:0]           w_apos;
    logic [2:0]           w_ai;
    logic [31:0]          w_pix;
    logic [7:0]           w_alpha;

    assign w_load = !i_stat.empty && (!r_out_v || i_ready);
    assign o_pop  = w_load && (r_k == 4'd15);

    always_comb begin
        // The first texel of a block starts from the block's own base index.
        w_cur_base = (r_k == 4'd0) ? i_blk.base : r_row_base;
        w_ci       = i_blk.cidx[{r_k, 1'b0} +: 2];
        w_apos     = 6'(r_k) * 6'd3;
        w_ai       = i_blk.aidx[w_apos +: 3];
        w_pix      = i_blk.pal[w_ci];
        w_alpha    = i_blk.dxt5 ? i_blk.apal[w_ai] : w_pix[31:24];

        n_k        = w_load ? r_k + 4'd1 : r_k;
        n_row_base = r_row_base;
        if (w_load) begin
            n_row_base = (r_k[1:0] == 2'd3) ? w_cur_base + i_blk.step : w_cur_base;
        end
        n_out_v = r_out_v;
        if (w_load) begin
            n_out_v = 1'b1;
        end else if (i_ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= 4'd0;
            r_out_v <= 1'b0;
        end else begin
            r_k     <= n_k;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_base <= n_row_base;
        if (w_load) begin
            r_data <= {w_cur_base + PIX_IDX_W'(r_k[1:0]), w_alpha, w_pix[23:0]};
            r_last <= (r_k == 4'd15);
            r_user <= (r_k == 4'd15) && i_blk.last_img;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_user  = r_user;

endmodule

// ===== design/dxt1_dxt5_block_decoder_core.sv =====
// Top level of the DXT1/DXT5 block decoder: configuration registers and block wiring.
// A block goes through the front end's staging register and the queue before its pixels
// reach the output register. Throughput: one pixel per cycle unless stalled, set by the
// pixel engine that walks a block's sixteen texels through a single output register.
// Reset (synchronous, active low) clears block counters, queue and output, and sets
// DXT1 mode with a 4x4 image.
`timescale 1ns / 1ps

module dxt1_dxt5_block_decoder_core #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [12:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] block_low, [127:64] block_high
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,   // red, green, blue, alpha, pixel_index[23:0]
    output logic         m_axis_tlast,
    output logic [0:0]   m_axis_tuser    // last_in_image
);
    import dxtdec_pkg::*;

    t_cfg    r_cfg, n_cfg;
    t_blk    w_push_blk, w_head_blk;
    t_q_stat w_q_stat;
    logic    w_push, w_pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_FORMAT: n_cfg.fmt_dxt5 = i_cfg_data[0];
                CFG_IDX_WIDTH:  n_cfg.width    = i_cfg_data;
                CFG_IDX_HEIGHT: n_cfg.height   = i_cfg_data;
                default:        n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt_dxt5 <= 1'b0;
            r_cfg.width    <= 13'd4;
            r_cfg.height   <= 13'd4;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    dxtdec_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_push  (w_push),
        .o_blk   (w_push_blk),
        .i_full  (w_q_stat.full)
    );

    dxtdec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_blk   (w_push_blk),
        .i_pop   (w_pop),
        .o_blk   (w_head_blk),
        .o_stat  (w_q_stat)
    );

    dxtdec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (w_head_blk),
        .i_stat  (w_q_stat),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_user  (m_axis_tuser[0])
    );

    // The end of the image can only be flagged on the last pixel of a block.
    a_image_end_on_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("image end flagged away from a block end");

    // Retiring a queue entry coincides with loading the sixteenth pixel of that block.
    a_pop_on_last_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> m_axis_tvalid && m_axis_tlast)
        else $error("queue entry retired before its last pixel");

    // The front end never writes into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("block header pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("block header popped from an empty queue");

endmodule

// ===== tb/tb_dxt1_dxt5_block_decoder_core.sv =====
// Self-checking testbench of the DXT1/DXT5 block decoder: directed blocks, then random phases.
`timescale 1ns / 1ps

module tb_dxt1_dxt5_block_decoder_core;

    import dxtdec_pkg::*;

    localparam int MAX_DIM = 4096;
    localparam int QUIET_LIMIT = 4000;
    localparam int N_DIRECTED = 22;
    localparam int N_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 14;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic [7:0]           alpha;
        logic [PIX_IDX_W-1:0] pix_index;
        logic                 last_blk;
        logic                 last_img;
    } t_pixel;

    typedef struct packed {
        logic        fmt;
        logic [12:0] width;
        logic [12:0] height;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        typed;
        logic [31:0] rgba;     // {alpha, blue, green, red} for every pixel of the block
    } t_blk_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = CFG_IDX_FORMAT;
    logic [12:0]  i_cfg_data = 13'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = 128'd0;   // [63:0] block_low, [127:64] block_high
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;            // red, green, blue, alpha, pixel_index[23:0]
    logic         m_axis_tlast;
    logic [0:0]   m_axis_tuser;            // last_in_image

    t_pixel   pending_pixels[$];
    t_blk_row directed_rows [0:N_DIRECTED-1];
    int       mismatches = 0;
    int       quiet_cycles = 0;
    int       stall_pct = 0;
    int       send_idle_pct = 0;

    // Shadow of the decoder's configuration and block position.
    logic        cur_fmt = 1'b0;
    logic [12:0] cur_width = 13'd4;
    logic [12:0] cur_height = 13'd4;
    int          col_pos = 0;
    int          row_pos = 0;

    dxt1_dxt5_block_decoder_core #(
        .MAX_DIMENSION(MAX_DIM)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int rounded_dim(logic [12:0] v);
        int r;
        r = int'(v) & ~3;
        if (r < 4) r = 4;
        if (r > MAX_DIM) r = MAX_DIM;
        return r;
    endfunction

    // Works out the sixteen pixels of one block and advances the block position.
    task automatic decode_block_expect(logic [63:0] lo, logic [63:0] hi,
                                       logic typed, logic [31:0] rgba);
        int unsigned pal [4][4];
        int unsigned apal [8];
        int unsigned v;
        int unsigned c0;
        int unsigned c1;
        int          w;
        int          h;
        int          ci;
        int          ai;
        bit          last_col;
        bit          last_row;
        logic [63:0] cw;
        longint unsigned pos;
        t_pixel      px;
        cw = cur_fmt ? hi : lo;
        w = rounded_dim(cur_width);
        h = rounded_dim(cur_height);
        last_col = (col_pos + 1) >= (w >> 2);
        last_row = (row_pos + 1) >= (h >> 2);
        for (int e = 0; e < 2; e++) begin
            v = 32'(cw[16*e +: 16]);
            pal[e][0] = ((v >> 8) & 'hf8) | ((v >> 13) & 'h7);
            pal[e][1] = ((v >> 3) & 'hfc) | ((v >> 9) & 'h3);
            pal[e][2] = ((v << 3) & 'hf8) | ((v >> 2) & 'h7);
            pal[e][3] = 255;
        end
        c0 = 32'(cw[15:0]);
        c1 = 32'(cw[31:16]);
        for (int ch = 0; ch < 3; ch++) begin
            if (cur_fmt || c0 > c1) begin
                pal[2][ch] = (pal[0][ch] * 2 + pal[1][ch]) / 3;
                pal[3][ch] = (pal[0][ch] + pal[1][ch] * 2) / 3;
            end else begin
                pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
                pal[3][ch] = 0;
            end
        end
        pal[2][3] = 255;
        pal[3][3] = (cur_fmt || c0 > c1) ? 255 : 0;

        apal[0] = 32'(lo[7:0]);
        apal[1] = 32'(lo[15:8]);
        if (apal[0] > apal[1]) begin
            for (int i = 1; i < 7; i++) apal[i+1] = (apal[0] * (7 - i) + apal[1] * i) / 7;
        end else begin
            for (int i = 1; i < 5; i++) apal[i+1] = (apal[0] * (5 - i) + apal[1] * i) / 5;
            apal[6] = 0;
            apal[7] = 255;
        end

        for (int k = 0; k < 16; k++) begin
            ci = int'(cw[32 + 2*k +: 2]);
            ai = int'(lo[16 + 3*k +: 3]);
            px.red = 8'(pal[ci][0]);
            px.green = 8'(pal[ci][1]);
            px.blue = 8'(pal[ci][2]);
            px.alpha = cur_fmt ? 8'(apal[ai]) : 8'(pal[ci][3]);
            if (typed) {px.alpha, px.blue, px.green, px.red} = rgba;
            pos = (longint'(row_pos) * 4 + k / 4) * w + longint'(col_pos) * 4 + k % 4;
            px.pix_index = pos[PIX_IDX_W-1:0];
            px.last_blk = (k == 15);
            px.last_img = (k == 15) && last_col && last_row;
            pending_pixels.push_back(px);
        end

        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic send_block(logic [63:0] lo, logic [63:0] hi,
                              logic typed, logic [31:0] rgba);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {hi, lo};
        do @(posedge i_clk); while (!s_axis_tready);
        decode_block_expect(lo, hi, typed, rgba);
    endtask

    // Holds the sender back until every pixel has come out, then lets the pipeline settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [12:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IDX_FORMAT: cur_fmt = data[0];
            CFG_IDX_WIDTH:  cur_width = data;
            CFG_IDX_HEIGHT: cur_height = data;
            default: ;
        endcase
    endtask

    task automatic set_config(logic fmt, logic [12:0] w, logic [12:0] h);
        wait_drained();
        cfg_write(CFG_IDX_FORMAT, {12'd0, fmt});
        cfg_write(CFG_IDX_WIDTH, w);
        cfg_write(CFG_IDX_HEIGHT, h);
    endtask

    task automatic check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected nothing, got data %h last %b user %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("red", int'(want.red), int'(m_axis_tdata[7:0]));
                check_field("green", int'(want.green), int'(m_axis_tdata[15:8]));
                check_field("blue", int'(want.blue), int'(m_axis_tdata[23:16]));
                check_field("alpha", int'(want.alpha), int'(m_axis_tdata[31:24]));
                check_field("pixel_index", int'(want.pix_index), int'(m_axis_tdata[55:32]));
                check_field("last_in_block", int'(want.last_blk), int'(m_axis_tlast));
                check_field("last_in_image", int'(want.last_img), int'(m_axis_tuser[0]));
            end
        end
    end

    // Watchdog: a long stretch with no transfer on any channel means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] cw;
        logic [7:0]  tmp8;
        logic [15:0] tmp16;
        t_blk_row    row;

        // Typed rows decode to one colour over the whole block, so rgba covers every pixel.
        directed_rows = '{
            '{1'b0, 13'd4, 13'd4, 64'h0000_0000_0000_0000, 64'd0, 1'b1, 32'hFF00_0000},
            '{1'b0, 13'd4, 13'd4, 64'h0000_0000_0000_FFFF, 64'd0, 1'b1, 32'hFFFF_FFFF},
            '{1'b0, 13'd4, 13'd4, 64'hFFFF_FFFF_0000_FFFF, 64'd0, 1'b1, 32'hFF55_5555},
            '{1'b0, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_0000, 64'd0, 1'b1, 32'h0000_0000},
            '{1'b0, 13'd4, 13'd4, 64'hAAAA_AAAA_FFFF_0000, 64'd0, 1'b1, 32'hFF7F_7F7F},
            '{1'b0, 13'd4, 13'd4, 64'h5555_5555_FFFF_0000, 64'd0, 1'b1, 32'hFFFF_FFFF},
            '{1'b0, 13'd4, 13'd4, 64'h0000_0000_F800_F800, 64'd0, 1'b1, 32'hFF00_00FF},
            '{1'b0, 13'd4, 13'd4, 64'h0000_0000_07E0_07E0, 64'd0, 1'b1, 32'hFF00_FF00},
            '{1'b0, 13'd4, 13'd4, 64'h0000_0000_001F_001F, 64'd0, 1'b1, 32'hFFFF_0000},
            '{1'b0, 13'd4, 13'd4, 64'hE4E4_E4E4_07E0_F81F, 64'd0, 1'b0, 32'd0},
            '{1'b0, 13'd4, 13'd4, 64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
              1'b1, 32'hFF00_0000},
            '{1'b1, 13'd4, 13'd4, 64'h0000_0000_0000_0000, 64'd0, 1'b1, 32'h0000_0000},
            '{1'b1, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_0000, 64'd0, 1'b1, 32'hFF00_0000},
            '{1'b1, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_00FF, 64'd0, 1'b1, 32'h2400_0000},
            '{1'b1, 13'd4, 13'd4, 64'hDB6D_B6DB_6DB6_140A, 64'd0, 1'b1, 32'h0000_0000},
            '{1'b1, 13'd4, 13'd4, 64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_0000,
              1'b1, 32'hFFAA_AAAA},
            '{1'b1, 13'd4, 13'd4, 64'h1234_5678_9ABC_C840, 64'h9E37_79B9_7F4A_7C15,
              1'b0, 32'd0},
            '{1'b0, 13'd0, 13'd13, 64'h3333_3333_8410_7BEF, 64'd0, 1'b0, 32'd0},
            '{1'b0, 13'd0, 13'd13, 64'hF0F0_0F0F_2104_FFDF, 64'd0, 1'b0, 32'd0},
            '{1'b0, 13'd8191, 13'd8191, 64'h1B1B_1B1B_FFE0_001F, 64'd0, 1'b0, 32'd0},
            // Shrinking the image mid-way leaves the position beyond the new limits.
            '{1'b0, 13'd5, 13'd4, 64'h9C9C_9C9C_4208_C618, 64'd0, 1'b0, 32'd0},
            '{1'b0, 13'd4097, 13'd4097, 64'h0F0F_F0F0_1234_ABCD, 64'd0, 1'b0, 32'd0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_DIRECTED; n++) begin
            row = directed_rows[n];
            if (row.fmt != cur_fmt || row.width != cur_width || row.height != cur_height) begin
                wait_drained();
                if (row.fmt != cur_fmt) cfg_write(CFG_IDX_FORMAT, {12'd0, row.fmt});
                if (row.width != cur_width) cfg_write(CFG_IDX_WIDTH, row.width);
                if (row.height != cur_height) cfg_write(CFG_IDX_HEIGHT, row.height);
            end
            send_block(row.lo, row.hi, row.typed, row.rgba);
        end

        wait_drained();
        cfg_write(CFG_IDX_UNUSED, 13'h1FFF);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            send_idle_pct = (p % 4 == 1) ? 72 : (p % 4 == 3) ? 13 : 0;
            stall_pct = (p % 4 == 2) ? 72 : (p % 4 == 3) ? 13 : 0;
            case (p)
                0: set_config(1'b0, 13'd8, 13'd8);
                1: set_config(1'b1, 13'd12, 13'd4);
                2: set_config(1'b1, 13'd4, 13'd8);
                3: set_config(1'b0, 13'd8191, 13'd3);
                4: set_config(1'b1, 13'd7, 13'd4096);
                5: set_config(1'b0, 13'd16, 13'd16);
                6: set_config(1'b1, 13'd8, 13'd12);
                default: set_config(1'b0, 13'd4, 13'd4);
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
                cw = cur_fmt ? hi : lo;
                // Bias the endpoint ordering so both palette modes turn up often.
                case ($urandom_range(5))
                    0: cw[31:16] = cw[15:0];
                    1: if (cw[15:0] > cw[31:16]) begin
                        tmp16 = cw[15:0];
                        cw[15:0] = cw[31:16];
                        cw[31:16] = tmp16;
                    end
                    2: if (cw[15:0] < cw[31:16]) begin
                        tmp16 = cw[15:0];
                        cw[15:0] = cw[31:16];
                        cw[31:16] = tmp16;
                    end
                    3: cw[15:8] = cw[7:0];
                    4: if (cw[7:0] > cw[15:8]) begin
                        tmp8 = cw[7:0];
                        cw[7:0] = cw[15:8];
                        cw[15:8] = tmp8;
                    end
                    default: ;
                endcase
                if (cur_fmt) hi = cw;
                else lo = cw;
                // Alpha endpoints live in block_low whatever the colour word is.
                if ($urandom_range(3) == 0) lo[15:8] = lo[7:0];
                if (p == 5 && i == ITEMS_PER_PHASE / 2) wait_drained();
                send_block(lo, hi, 1'b0, 32'd0);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/dxtdec_pkg.sv
design/dxtdec_front.sv
design/dxtdec_fifo.sv
design/dxtdec_back.sv
design/dxt1_dxt5_block_decoder_core.sv
tb/tb_dxt1_dxt5_block_decoder_core.sv
